>>> hw/rtl/djd_pkg.sv
// Shared types, sizes and codes of the dataflow job dispatcher.
package djd_pkg;

   localparam int BUFFERS        = 256;
   localparam int JOB_SLOTS      = 64;
   localparam int THREAD_SLOTS   = 16;
   localparam int MAX_JOB_INPUTS = 9;
   localparam int MAX_DISPATCH   = 15;

   localparam int BUF_AW  = $clog2(BUFFERS);
   localparam int BUF_CW  = $clog2(BUFFERS + 1);
   localparam int JOB_AW  = $clog2(JOB_SLOTS);
   localparam int JOB_CW  = $clog2(JOB_SLOTS + 1);
   localparam int WRK_AW  = $clog2(THREAD_SLOTS);
   localparam int CNT_W   = $clog2(MAX_JOB_INPUTS + 1);
   localparam int LIST_N  = JOB_SLOTS * MAX_JOB_INPUTS;
   localparam int LIST_AW = $clog2(LIST_N);
   localparam int CLR_N   = (BUFFERS > JOB_SLOTS) ? BUFFERS : JOB_SLOTS;
   localparam int CLR_W   = $clog2(CLR_N);
   localparam int REF_W   = 16;

   localparam logic [2:0] F_NEW    = 3'd0;
   localparam logic [2:0] F_OPEN   = 3'd1;
   localparam logic [2:0] F_REL    = 3'd2;
   localparam logic [2:0] F_DROP   = 3'd3;
   localparam logic [2:0] F_SUBMIT = 3'd4;
   localparam logic [2:0] F_IDLE   = 3'd5;
   localparam logic [2:0] F_DONE   = 3'd6;
   localparam logic [2:0] F_QUERY  = 3'd7;

   localparam logic [1:0] BS_FREE  = 2'd0;
   localparam logic [1:0] BS_AWAIT = 2'd1;
   localparam logic [1:0] BS_OPEN  = 2'd2;
   localparam logic [1:0] BS_REL   = 2'd3;

   localparam logic [1:0] JS_FREE = 2'd0;
   localparam logic [1:0] JS_WAIT = 2'd1;
   localparam logic [1:0] JS_RUN  = 2'd2;

   localparam logic [2:0] E_NONE    = 3'd0;
   localparam logic [2:0] E_NOBUF   = 3'd1;
   localparam logic [2:0] E_NOTAWT  = 3'd2;
   localparam logic [2:0] E_NOSLOT  = 3'd3;
   localparam logic [2:0] E_INPUTS  = 3'd4;

   typedef struct packed {
      logic [2:0] func;
      logic [7:0] buffer_id;
      logic [7:0] program_req;
      logic       last_input;
      logic [5:0] job_id;
      logic [3:0] worker_id;
      logic       buf_ok;
      logic       job_ok;
      logic       wrk_ok;
   } event_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] new_buffer;
      logic       buffer_ready;
      logic [2:0] error;
      logic [5:0] dispatched_job;
      logic [3:0] dispatched_worker;
      logic [7:0] dispatched_program;
      logic       last_result;
   } result_type;

   typedef struct packed {
      logic clearing;
      logic take;
   } back_status_type;

endpackage

>>> hw/rtl/djd_front.sv
// Request intake: classify each request and hold it in a short queue.
module djd_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [2:0]                  req_func,
   input  logic [7:0]                  req_buffer_id,
   input  logic [7:0]                  req_program_req,
   input  logic                        req_last_input,
   input  logic [5:0]                  req_job_id,
   input  logic [3:0]                  req_worker_id,
   input  djd_pkg::back_status_type    status,
   output logic                        q_valid,
   output djd_pkg::event_type          q_event
);
   import djd_pkg::*;

   localparam int QD = 4;
   localparam int QAW = $clog2(QD);

   event_type           fifo_ff [QD];
   logic [QAW-1:0]      wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QAW:0]        count_ff, count_in;
   event_type           ev;
   logic                push, pop;

   always_comb begin
      ev.func        = req_func;
      ev.buffer_id   = req_buffer_id;
      ev.program_req = req_program_req;
      ev.last_input  = req_last_input;
      ev.job_id      = req_job_id;
      ev.worker_id   = req_worker_id;
      ev.buf_ok      = (req_buffer_id != 8'd0) && (32'(req_buffer_id) < BUFFERS);
      ev.job_ok      = (req_job_id != 6'd0) && (32'(req_job_id) < JOB_SLOTS);
      ev.wrk_ok      = (req_worker_id != 4'd0) && (32'(req_worker_id) < THREAD_SLOTS);
   end

   assign req_ready = (32'(count_ff) < QD) && !status.clearing;
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign pop       = status.take && q_valid;
   assign q_event   = fifo_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QAW+1)'(push) - (QAW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= ev;
      end
   end

endmodule

>>> hw/rtl/djd_back.sv
// Event sequencer: buffer and job tables, dispatch scan and result register.
module djd_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   input  djd_pkg::event_type          q_event,
   output djd_pkg::back_status_type    status,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output djd_pkg::result_type         rsp
);
   import djd_pkg::*;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_CLR    = 4'd1;
   localparam logic [3:0] ST_DEC    = 4'd2;
   localparam logic [3:0] ST_NB_RD  = 4'd3;
   localparam logic [3:0] ST_NB_CHK = 4'd4;
   localparam logic [3:0] ST_BOP    = 4'd5;
   localparam logic [3:0] ST_JS_RD  = 4'd6;
   localparam logic [3:0] ST_JS_CHK = 4'd7;
   localparam logic [3:0] ST_SUB    = 4'd8;
   localparam logic [3:0] ST_SCAN   = 4'd9;
   localparam logic [3:0] ST_JCHK   = 4'd10;
   localparam logic [3:0] ST_IN     = 4'd11;
   localparam logic [3:0] ST_INB    = 4'd12;
   localparam logic [3:0] ST_INC    = 4'd13;
   localparam logic [3:0] ST_DISP   = 4'd14;
   localparam logic [3:0] ST_FIN    = 4'd15;

   logic [3:0]          state_ff, state_in;
   logic [CLR_W-1:0]    clr_ff, clr_in;
   event_type           ev_ff, ev_in;
   logic [BUF_CW-1:0]   bi_ff, bi_in;
   logic [JOB_CW-1:0]   j_ff, j_in;
   logic [CNT_W-1:0]    k_ff, k_in, lim_ff, lim_in;
   logic [7:0]          prog_ff, prog_in;
   logic [3:0]          n_ff, n_in;
   result_type          pend_ff, pend_in, out_ff, out_in;
   logic                out_valid_ff, out_valid_in;
   logic [THREAD_SLOTS-1:0] busy_ff, busy_in;
   logic                sub_open_ff, sub_open_in, sub_failed_ff, sub_failed_in;
   logic [JOB_AW-1:0]   sub_slot_ff, sub_slot_in;
   logic [CNT_W-1:0]    sub_cnt_ff, sub_cnt_in;

   logic [REF_W+1:0]    bmem [BUFFERS];
   logic [REF_W+1:0]    brd_ff;
   logic [1:0]          jst [JOB_SLOTS];
   logic [1:0]          jst_rd_ff;
   logic [7:0]          jprog [JOB_SLOTS];
   logic [7:0]          jprog_rd_ff;
   logic [CNT_W-1:0]    jcnt [JOB_SLOTS];
   logic [CNT_W-1:0]    jcnt_rd_ff;
   logic [7:0]          jlist [LIST_N];
   logic [7:0]          jlist_rd_ff;

   logic                b_we, js_we, jp_we, jc_we, jl_we;
   logic [BUF_AW-1:0]   b_wa, b_ra;
   logic [REF_W+1:0]    b_wd;
   logic [JOB_AW-1:0]   js_wa, js_ra, jp_wa, jc_wa;
   logic [1:0]          js_wd;
   logic [7:0]          jp_wd, jl_wd;
   logic [CNT_W-1:0]    jc_wd;
   logic [LIST_AW-1:0]  jl_wa, jl_ra;

   logic [1:0]          b_st;
   logic [REF_W-1:0]    b_cnt;
   logic [BUF_AW-1:0]   ev_bidx;
   logic [JOB_AW-1:0]   jidx;
   logic                wr_found;
   logic [WRK_AW-1:0]   wr_idx;
   logic                out_free;

   assign b_st     = brd_ff[REF_W+1:REF_W];
   assign b_cnt    = brd_ff[REF_W-1:0];
   assign ev_bidx  = BUF_AW'(ev_ff.buffer_id);
   assign jidx     = j_ff[JOB_AW-1:0];
   assign js_ra    = jidx;
   assign jl_ra    = LIST_AW'(32'(jidx) * MAX_JOB_INPUTS + 32'(k_ff));
   assign out_free = !out_valid_ff || rsp_ready;

   assign status.clearing = (state_ff == ST_CLR);
   assign status.take     = (state_ff == ST_IDLE) && q_valid;
   assign rsp_valid       = out_valid_ff;
   assign rsp             = out_ff;

   always_comb begin
      wr_found = 1'b0;
      wr_idx   = '0;
      for (int w = THREAD_SLOTS - 1; w >= 1; w--) begin
         if (!busy_ff[w]) begin
            wr_found = 1'b1;
            wr_idx   = WRK_AW'(w);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      ev_in         = ev_ff;
      bi_in         = bi_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      lim_in        = lim_ff;
      prog_in       = prog_ff;
      n_in          = n_ff;
      pend_in       = pend_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      busy_in       = busy_ff;
      sub_open_in   = sub_open_ff;
      sub_failed_in = sub_failed_ff;
      sub_slot_in   = sub_slot_ff;
      sub_cnt_in    = sub_cnt_ff;
      b_we  = 1'b0;  b_wa  = ev_bidx;  b_wd = brd_ff;  b_ra = ev_bidx;
      js_we = 1'b0;  js_wa = jidx;     js_wd = JS_FREE;
      jp_we = 1'b0;  jp_wa = sub_slot_ff; jp_wd = ev_ff.program_req;
      jc_we = 1'b0;  jc_wa = sub_slot_ff; jc_wd = '0;
      jl_we = 1'b0;
      jl_wa = LIST_AW'(32'(sub_slot_ff) * MAX_JOB_INPUTS + 32'(sub_cnt_ff));
      jl_wd = ev_ff.buffer_id;

      unique case (state_ff)
         ST_CLR: begin
            b_we  = (32'(clr_ff) < BUFFERS);
            b_wa  = BUF_AW'(clr_ff);
            b_wd  = '0;
            js_we = (32'(clr_ff) < JOB_SLOTS);
            js_wa = JOB_AW'(clr_ff);
            js_wd = JS_FREE;
            clr_in = clr_ff + 1'b1;
            if (32'(clr_ff) == CLR_N - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               ev_in    = q_event;
               state_in = ST_DEC;
            end
         end
         ST_DEC: begin
            pend_in = '0;
            j_in    = JOB_CW'(1);
            n_in    = '0;
            unique case (ev_ff.func)
               F_NEW: begin
                  bi_in    = BUF_CW'(1);
                  state_in = ST_NB_RD;
               end
               F_OPEN, F_REL, F_DROP, F_QUERY: begin
                  if (ev_ff.buf_ok) begin
                     state_in = ST_BOP;
                  end else begin
                     if (ev_ff.func == F_OPEN) begin
                        pend_in.error = E_NOTAWT;
                     end
                     state_in = ST_SCAN;
                  end
               end
               F_SUBMIT: begin
                  if (sub_open_ff) begin
                     state_in = ST_SUB;
                  end else begin
                     j_in     = JOB_CW'(1);
                     state_in = ST_JS_RD;
                  end
               end
               F_IDLE: begin
                  if (ev_ff.wrk_ok) begin
                     busy_in[WRK_AW'(ev_ff.worker_id)] = 1'b0;
                  end
                  state_in = ST_SCAN;
               end
               default: begin
                  js_we    = ev_ff.job_ok;
                  js_wa    = JOB_AW'(ev_ff.job_id);
                  js_wd    = JS_FREE;
                  state_in = ST_SCAN;
               end
            endcase
         end
         ST_NB_RD: begin
            b_ra     = BUF_AW'(bi_ff);
            state_in = ST_NB_CHK;
         end
         ST_NB_CHK: begin
            if (b_st == BS_FREE) begin
               b_we               = 1'b1;
               b_wa               = BUF_AW'(bi_ff);
               b_wd               = {BS_AWAIT, REF_W'(1)};
               pend_in.new_buffer = 8'(bi_ff);
               state_in           = ST_SCAN;
            end else if (32'(bi_ff) + 1 >= BUFFERS) begin
               pend_in.error = E_NOBUF;
               state_in      = ST_SCAN;
            end else begin
               bi_in    = bi_ff + 1'b1;
               state_in = ST_NB_RD;
            end
         end
         ST_BOP: begin
            state_in = ST_SCAN;
            j_in     = JOB_CW'(1);
            n_in     = '0;
            unique case (ev_ff.func)
               F_OPEN: begin
                  if (b_st == BS_AWAIT) begin
                     b_we = 1'b1;
                     b_wd = {BS_OPEN, b_cnt};
                  end else begin
                     pend_in.error = E_NOTAWT;
                  end
               end
               F_SUBMIT: begin
                  if (b_cnt != {REF_W{1'b1}}) begin
                     b_we = 1'b1;
                     b_wd = {b_st, b_cnt + 1'b1};
                  end
               end
               F_QUERY: begin
                  pend_in.buffer_ready = (b_st == BS_REL);
               end
               default: begin
                  if (ev_ff.func == F_REL && b_st == BS_OPEN) begin
                     b_we = 1'b1;
                     b_wd = {BS_REL, b_cnt};
                  end else if (b_cnt != '0) begin
                     b_we = 1'b1;
                     b_wd = {(b_cnt == REF_W'(1)) ? BS_FREE : b_st, b_cnt - 1'b1};
                  end
               end
            endcase
         end
         ST_JS_RD: begin
            state_in = ST_JS_CHK;
         end
         ST_JS_CHK: begin
            if (jst_rd_ff == JS_FREE) begin
               sub_open_in   = 1'b1;
               sub_failed_in = 1'b0;
               sub_slot_in   = jidx;
               sub_cnt_in    = '0;
               jc_we         = 1'b1;
               jc_wa         = jidx;
               jc_wd         = '0;
               state_in      = ST_SUB;
            end else if (32'(j_ff) + 1 >= JOB_SLOTS) begin
               sub_open_in   = 1'b1;
               sub_failed_in = 1'b1;
               state_in      = ST_SUB;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = ST_JS_RD;
            end
         end
         ST_SUB: begin
            state_in = ST_SCAN;
            j_in     = JOB_CW'(1);
            n_in     = '0;
            if (sub_failed_ff) begin
               pend_in.error = E_NOSLOT;
            end else if (ev_ff.buffer_id != 8'd0) begin
               if (32'(sub_cnt_ff) >= MAX_JOB_INPUTS) begin
                  pend_in.error = E_INPUTS;
               end else begin
                  jl_we      = 1'b1;
                  jc_we      = 1'b1;
                  jc_wd      = sub_cnt_ff + 1'b1;
                  sub_cnt_in = sub_cnt_ff + 1'b1;
                  if (ev_ff.buf_ok) begin
                     state_in = ST_BOP;
                  end
               end
            end
            if (ev_ff.last_input) begin
               if (!sub_failed_ff) begin
                  jp_we = 1'b1;
                  js_we = 1'b1;
                  js_wa = sub_slot_ff;
                  js_wd = JS_WAIT;
               end
               sub_open_in   = 1'b0;
               sub_failed_in = 1'b0;
            end
         end
         ST_SCAN: begin
            if (32'(j_ff) >= JOB_SLOTS || 32'(n_ff) == MAX_DISPATCH || !wr_found) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_JCHK;
            end
         end
         ST_JCHK: begin
            if (jst_rd_ff == JS_WAIT) begin
               lim_in   = jcnt_rd_ff;
               prog_in  = jprog_rd_ff;
               k_in     = '0;
               state_in = ST_IN;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_IN: begin
            if (k_ff >= lim_ff) begin
               state_in = ST_DISP;
            end else begin
               state_in = ST_INB;
            end
         end
         ST_INB: begin
            b_ra = BUF_AW'(jlist_rd_ff);
            if (32'(jlist_rd_ff) >= BUFFERS) begin
               j_in     = j_ff + 1'b1;
               state_in = ST_SCAN;
            end else begin
               state_in = ST_INC;
            end
         end
         ST_INC: begin
            if (b_st == BS_REL) begin
               k_in     = k_ff + 1'b1;
               state_in = ST_IN;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_DISP: begin
            if (out_free) begin
               out_in                     = pend_ff;
               out_in.last_result         = 1'b0;
               out_valid_in               = 1'b1;
               pend_in                    = '0;
               pend_in.kind               = 1'b1;
               pend_in.dispatched_job     = 6'(j_ff);
               pend_in.dispatched_worker  = 4'(wr_idx);
               pend_in.dispatched_program = prog_ff;
               js_we                      = 1'b1;
               js_wd                      = JS_RUN;
               busy_in[wr_idx]            = 1'b1;
               n_in                       = n_ff + 1'b1;
               j_in                       = j_ff + 1'b1;
               state_in                   = ST_SCAN;
            end
         end
         default: begin
            if (out_free) begin
               out_in             = pend_ff;
               out_in.last_result = 1'b1;
               out_valid_in       = 1'b1;
               state_in           = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLR;
         clr_ff        <= '0;
         out_valid_ff  <= 1'b0;
         busy_ff       <= '1;
         sub_open_ff   <= 1'b0;
         sub_failed_ff <= 1'b0;
         sub_slot_ff   <= '0;
         sub_cnt_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         out_valid_ff  <= out_valid_in;
         busy_ff       <= busy_in;
         sub_open_ff   <= sub_open_in;
         sub_failed_ff <= sub_failed_in;
         sub_slot_ff   <= sub_slot_in;
         sub_cnt_ff    <= sub_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      ev_ff   <= ev_in;
      bi_ff   <= bi_in;
      j_ff    <= j_in;
      k_ff    <= k_in;
      lim_ff  <= lim_in;
      prog_ff <= prog_in;
      n_ff    <= n_in;
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   always_ff @(posedge clock) begin
      if (b_we) begin
         bmem[b_wa] <= b_wd;
      end
      brd_ff <= bmem[b_ra];
   end

   always_ff @(posedge clock) begin
      if (js_we) begin
         jst[js_wa] <= js_wd;
      end
      jst_rd_ff <= jst[js_ra];
   end

   always_ff @(posedge clock) begin
      if (jp_we) begin
         jprog[jp_wa] <= jp_wd;
      end
      jprog_rd_ff <= jprog[js_ra];
   end

   always_ff @(posedge clock) begin
      if (jc_we) begin
         jcnt[jc_wa] <= jc_wd;
      end
      jcnt_rd_ff <= jcnt[js_ra];
   end

   always_ff @(posedge clock) begin
      if (jl_we) begin
         jlist[jl_wa] <= jl_wd;
      end
      jlist_rd_ff <= jlist[jl_ra];
   end

endmodule

>>> hw/rtl/dataflow_job_dispatcher.sv
// Top level of the dataflow job dispatcher: request queue and event sequencer.
// For a new buffer request the buffer entries are searched in turn; the acknowledgement of
// every request then waits for the dispatch scan over the job slots and the inputs of each
// waiting job to find its first job or to end, through the single read port of each table;
// one request is worked at a time.
// Reset runs a clearing pass over the buffer and job tables with req_ready low.
module dataflow_job_dispatcher (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_func,
   input  logic [7:0] req_buffer_id,
   input  logic [7:0] req_program_req,
   input  logic       req_last_input,
   input  logic [5:0] req_job_id,
   input  logic [3:0] req_worker_id,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_kind,
   output logic [7:0] rsp_new_buffer,
   output logic       rsp_buffer_ready,
   output logic [2:0] rsp_error,
   output logic [5:0] rsp_dispatched_job,
   output logic [3:0] rsp_dispatched_worker,
   output logic [7:0] rsp_dispatched_program,
   output logic       rsp_last_result
);
   import djd_pkg::*;

   back_status_type status;
   logic            q_valid;
   event_type       q_event;
   result_type      rsp;

   djd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_buffer_id   (req_buffer_id),
      .req_program_req (req_program_req),
      .req_last_input  (req_last_input),
      .req_job_id      (req_job_id),
      .req_worker_id   (req_worker_id),
      .status          (status),
      .q_valid         (q_valid),
      .q_event         (q_event)
   );

   djd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_event   (q_event),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_kind               = rsp.kind;
   assign rsp_new_buffer         = rsp.new_buffer;
   assign rsp_buffer_ready       = rsp.buffer_ready;
   assign rsp_error              = rsp.error;
   assign rsp_dispatched_job     = rsp.dispatched_job;
   assign rsp_dispatched_worker  = rsp.dispatched_worker;
   assign rsp_dispatched_program = rsp.dispatched_program;
   assign rsp_last_result        = rsp.last_result;

endmodule

>>> dv/djd_checker.sv
// Checker for the dataflow job dispatcher: watches both channels, predicts results, compares.
module djd_checker
   import djd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [2:0] req_func,
   input  logic [7:0] req_buffer_id,
   input  logic [7:0] req_program_req,
   input  logic       req_last_input,
   input  logic [5:0] req_job_id,
   input  logic [3:0] req_worker_id,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic       rsp_kind,
   input  logic [7:0] rsp_new_buffer,
   input  logic       rsp_buffer_ready,
   input  logic [2:0] rsp_error,
   input  logic [5:0] rsp_dispatched_job,
   input  logic [3:0] rsp_dispatched_worker,
   input  logic [7:0] rsp_dispatched_program,
   input  logic       rsp_last_result,
   output int         fail_count,
   output int         pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [1:0]  buf_state [BUFFERS];
   logic [15:0] buf_refs  [BUFFERS];
   logic [1:0]  job_state [JOB_SLOTS];
   logic [7:0]  job_prog  [JOB_SLOTS];
   logic [7:0]  job_inputs[JOB_SLOTS][MAX_JOB_INPUTS];
   logic [3:0]  job_count [JOB_SLOTS];
   logic        wrk_busy  [THREAD_SLOTS];
   logic        sub_open;
   int          sub_slot;
   logic        sub_failed;
   result_type  expected_results[$];

   assign pending = expected_results.size();

   task clear_tables();
      for (int i = 0; i < BUFFERS; i++) begin
         buf_state[i] = BS_FREE;
         buf_refs[i]  = '0;
      end
      for (int i = 0; i < JOB_SLOTS; i++) begin
         job_state[i] = JS_FREE;
         job_prog[i]  = '0;
         job_count[i] = '0;
         for (int k = 0; k < MAX_JOB_INPUTS; k++) job_inputs[i][k] = '0;
      end
      for (int i = 0; i < THREAD_SLOTS; i++) wrk_busy[i] = 1'b1;
      sub_open   = 1'b0;
      sub_slot   = 0;
      sub_failed = 1'b0;
   endtask

   task drop_ref(input logic [7:0] b);
      if (b != 0 && buf_refs[b] != 0) begin
         buf_refs[b] = buf_refs[b] - 16'd1;
         if (buf_refs[b] == 0) buf_state[b] = BS_FREE;
      end
   endtask

   function automatic logic inputs_released(input int j);
      for (int i = 0; i < job_count[j] && i < MAX_JOB_INPUTS; i++)
         if (buf_state[job_inputs[j][i]] != BS_REL) return 1'b0;
      return 1'b1;
   endfunction

   task automatic predict_event(input logic [2:0] f, input logic [7:0] b, input logic [7:0] p,
                                input logic l, input logic [5:0] jid, input logic [3:0] wid);
      int         i;
      int         j;
      int         w;
      int         c;
      result_type r;
      result_type burst[$];
      r = '0;
      case (f)
         F_NEW: begin
            for (i = 1; i < BUFFERS; i++) if (buf_state[i] == BS_FREE) break;
            if (i < BUFFERS) begin
               buf_state[i] = BS_AWAIT;
               buf_refs[i]  = 16'd1;
               r.new_buffer = i[7:0];
            end else r.error = E_NOBUF;
         end
         F_OPEN: begin
            if (b != 0 && buf_state[b] == BS_AWAIT) buf_state[b] = BS_OPEN;
            else r.error = E_NOTAWT;
         end
         F_REL: begin
            if (b != 0 && buf_state[b] == BS_OPEN) buf_state[b] = BS_REL;
            else drop_ref(b);
         end
         F_DROP: drop_ref(b);
         F_SUBMIT: begin
            if (!sub_open) begin
               sub_open   = 1'b1;
               sub_failed = 1'b0;
               for (i = 1; i < JOB_SLOTS; i++) if (job_state[i] == JS_FREE) break;
               if (i < JOB_SLOTS) begin
                  sub_slot     = i;
                  job_count[i] = '0;
               end else sub_failed = 1'b1;
            end
            if (sub_failed) r.error = E_NOSLOT;
            else if (b != 0) begin
               c = job_count[sub_slot];
               if (c >= MAX_JOB_INPUTS) r.error = E_INPUTS;
               else begin
                  job_inputs[sub_slot][c] = b;
                  job_count[sub_slot]     = 4'(c + 1);
                  if (buf_refs[b] != 16'hFFFF) buf_refs[b] = buf_refs[b] + 16'd1;
               end
            end
            if (l) begin
               if (!sub_failed) begin
                  job_prog[sub_slot]  = p;
                  job_state[sub_slot] = JS_WAIT;
               end
               sub_open   = 1'b0;
               sub_failed = 1'b0;
            end
         end
         F_IDLE: if (wid != 0) wrk_busy[wid] = 1'b0;
         F_DONE: if (jid != 0) job_state[jid] = JS_FREE;
         default: r.buffer_ready = (b != 0 && buf_state[b] == BS_REL);
      endcase
      burst.push_back(r);
      while (burst.size() <= MAX_DISPATCH) begin
         for (j = 1; j < JOB_SLOTS; j++)
            if (job_state[j] == JS_WAIT && inputs_released(j)) break;
         if (j >= JOB_SLOTS) break;
         for (w = 1; w < THREAD_SLOTS; w++) if (!wrk_busy[w]) break;
         if (w >= THREAD_SLOTS) break;
         wrk_busy[w]  = 1'b1;
         job_state[j] = JS_RUN;
         r = '0;
         r.kind               = 1'b1;
         r.dispatched_job     = j[5:0];
         r.dispatched_worker  = w[3:0];
         r.dispatched_program = job_prog[j];
         burst.push_back(r);
      end
      burst[burst.size()-1].last_result = 1'b1;
      foreach (burst[k]) expected_results.push_back(burst[k]);
   endtask

   task report(input string what, input int got, input int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   task compare_result();
      result_type e;
      if (expected_results.size() == 0) begin
         report("unexpected result, kind", rsp_kind, -1);
         return;
      end
      e = expected_results.pop_front();
      if (rsp_kind !== e.kind) report("kind", rsp_kind, e.kind);
      if (rsp_new_buffer !== e.new_buffer) report("new_buffer", rsp_new_buffer, e.new_buffer);
      if (rsp_buffer_ready !== e.buffer_ready)
         report("buffer_ready", rsp_buffer_ready, e.buffer_ready);
      if (rsp_error !== e.error) report("error", rsp_error, e.error);
      if (rsp_dispatched_job !== e.dispatched_job)
         report("dispatched_job", rsp_dispatched_job, e.dispatched_job);
      if (rsp_dispatched_worker !== e.dispatched_worker)
         report("dispatched_worker", rsp_dispatched_worker, e.dispatched_worker);
      if (rsp_dispatched_program !== e.dispatched_program)
         report("dispatched_program", rsp_dispatched_program, e.dispatched_program);
      if (rsp_last_result !== e.last_result)
         report("last_result", rsp_last_result, e.last_result);
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         clear_tables();
         expected_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) compare_result();
         if (req_valid && req_ready)
            predict_event(req_func, req_buffer_id, req_program_req, req_last_input,
                          req_job_id, req_worker_id);
      end
   end

endmodule

>>> dv/tb_top.sv
// Testbench top for the dataflow job dispatcher: clock, reset, request stimulus and verdict.
module tb_top;
   import djd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT = 12000000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [2:0] req_func = F_QUERY;
   logic [7:0] req_buffer_id = '0;
   logic [7:0] req_program_req = '0;
   logic       req_last_input = 1'b0;
   logic [5:0] req_job_id = '0;
   logic [3:0] req_worker_id = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_kind;
   logic [7:0] rsp_new_buffer;
   logic       rsp_buffer_ready;
   logic [2:0] rsp_error;
   logic [5:0] rsp_dispatched_job;
   logic [3:0] rsp_dispatched_worker;
   logic [7:0] rsp_dispatched_program;
   logic       rsp_last_result;
   int         fail_count;
   int         pending;
   int         cycles = 0;
   logic       quiet = 1'b0;

   dataflow_job_dispatcher dut (.*);
   djd_checker checker_i (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      @(negedge clock);
      forever begin
         if (quiet) begin
            rsp_ready = 1'b1;
            @(negedge clock);
         end else begin
            rsp_ready = ($urandom_range(0, 2) != 0);
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end
      end
   end

   task send(input logic [2:0] f, input logic [7:0] b, input logic [7:0] p,
             input logic l, input logic [5:0] j, input logic [3:0] w);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_func        = f;
      req_buffer_id   = b;
      req_program_req = p;
      req_last_input  = l;
      req_job_id      = j;
      req_worker_id   = w;
      req_valid       = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [7:0] near_buffer();
      return ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 24));
   endfunction

   task submit_job(input int n, input logic finish);
      for (int i = 0; i < n; i++)
         send(F_SUBMIT, near_buffer(), 8'($urandom), finish && i == n - 1,
              6'($urandom), 4'($urandom));
   endtask

   initial begin
      int r;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send(F_QUERY, 8'd0, 8'd0, 1'b0, 6'd0, 4'd0);
      send(F_NEW, 8'd0, 8'd0, 1'b0, 6'd0, 4'd0);
      send(F_NEW, 8'd255, 8'd255, 1'b1, 6'd63, 4'd15);
      send(F_OPEN, 8'd1, 8'd0, 1'b0, 6'd0, 4'd0);
      send(F_OPEN, 8'd1, 8'd0, 1'b0, 6'd0, 4'd0);
      send(F_OPEN, 8'd0, 8'd0, 1'b0, 6'd0, 4'd0);
      send(F_REL, 8'd1, 8'd0, 1'b0, 6'd0, 4'd0);
      send(F_REL, 8'd2, 8'd0, 1'b0, 6'd0, 4'd0);
      send(F_DROP, 8'd2, 8'd0, 1'b0, 6'd0, 4'd0);
      send(F_DROP, 8'd0, 8'd0, 1'b0, 6'd0, 4'd0);
      send(F_QUERY, 8'd1, 8'd0, 1'b0, 6'd0, 4'd0);
      send(F_QUERY, 8'd255, 8'd0, 1'b0, 6'd0, 4'd0);
      send(F_SUBMIT, 8'd1, 8'd0, 1'b0, 6'd0, 4'd0);
      send(F_SUBMIT, 8'd0, 8'd0, 1'b0, 6'd0, 4'd0);
      send(F_SUBMIT, 8'd1, 8'd255, 1'b1, 6'd0, 4'd0);
      send(F_IDLE, 8'd0, 8'd0, 1'b0, 6'd0, 4'd0);
      send(F_IDLE, 8'd0, 8'd0, 1'b0, 6'd0, 4'd15);
      send(F_IDLE, 8'd0, 8'd0, 1'b0, 6'd0, 4'd1);
      send(F_DONE, 8'd0, 8'd0, 1'b0, 6'd0, 4'd0);
      send(F_DONE, 8'd0, 8'd0, 1'b0, 6'd63, 4'd0);
      send(F_DONE, 8'd0, 8'd0, 1'b0, 6'd1, 4'd0);
      for (int i = 0; i < 11; i++)
         send(F_SUBMIT, 8'd1, 8'hA5, i == 10, 6'd0, 4'd0);

      // fill the job table with input-free jobs, release workers, then complete all
      for (int i = 0; i < 70; i++) send(F_SUBMIT, 8'd0, 8'(i), 1'b1, 6'd0, 4'd0);
      for (int i = 1; i < 16; i++) send(F_IDLE, 8'd0, 8'd0, 1'b0, 6'd0, 4'(i));
      for (int i = 1; i < 64; i++) send(F_DONE, 8'd0, 8'd0, 1'b0, 6'(i), 4'd0);
      for (int i = 1; i < 16; i++) send(F_IDLE, 8'd0, 8'd0, 1'b0, 6'd0, 4'(i));

      for (int n = 0; n < 165; n++) begin
         if (n == 145) quiet = 1'b1;
         r = $urandom_range(0, 99);
         if (r < 14) send(F_NEW, 8'($urandom), 8'($urandom), 1'($urandom), 6'($urandom),
                          4'($urandom));
         else if (r < 26) send(F_OPEN, near_buffer(), 8'd0, 1'b0, 6'd0, 4'd0);
         else if (r < 40) send(F_REL, near_buffer(), 8'd0, 1'b0, 6'd0, 4'd0);
         else if (r < 45) send(F_DROP, near_buffer(), 8'd0, 1'b0, 6'd0, 4'd0);
         else if (r < 65) submit_job($urandom_range(1, 4), $urandom_range(0, 9) != 0);
         else if (r < 78) send(F_IDLE, 8'd0, 8'd0, 1'b0, 6'd0, 4'($urandom));
         else if (r < 88)
            send(F_DONE, 8'd0, 8'd0, 1'b0,
                 ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 12)),
                 4'd0);
         else if (r < 95) send(F_QUERY, near_buffer(), 8'd0, 1'b0, 6'd0, 4'd0);
         else send(3'($urandom), 8'($urandom), 8'($urandom), 1'($urandom), 6'($urandom),
                   4'($urandom));
      end
      send(F_SUBMIT, 8'd0, 8'd0, 1'b1, 6'd0, 4'd0);
      req_valid = 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (1000) @(posedge clock);
      if (fail_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
